// ===== hw/rtl/dss_pkg.sv =====
// Shared types and constants for the display sleep step sequencer.
// No dependencies; imported by dss_next_state and the top level.
package dss_pkg;

    // Step flag bit positions
    localparam int unsigned STEP_INIT  = 0;
    localparam int unsigned STEP_START = 1;
    localparam int unsigned STEP_ON    = 2;
    localparam int unsigned STEP_GTS   = 3;
    localparam int unsigned STEP_SLEEP = 4;
    localparam int unsigned STEP_WAKE  = 5;
    localparam int unsigned STEP_NEXT  = 6;

    localparam int unsigned NUM_STEPS = 7;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned MODE_W    = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_POWER_ON_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_IDLE_TIMEOUT     = 2'd1;
    localparam logic [1:0] REG_NOTICE           = 2'd2;
    localparam logic [1:0] REG_MODE_LIMIT       = 2'd3;

    // Register reset values
    localparam logic [MS_W-1:0]   POWER_ON_TIMEOUT_RST = 16'd60000;
    localparam logic [MS_W-1:0]   IDLE_TIMEOUT_RST     = 16'd30000;
    localparam logic [MS_W-1:0]   NOTICE_RST           = 16'd5000;
    localparam logic [MODE_W-1:0] MODE_LIMIT_RST       = 4'd3;

    localparam logic [NUM_STEPS-1:0] STEPS_RST = 7'b000_0001;

    typedef struct packed {
        logic [MS_W-1:0]   power_on_timeout_ms;
        logic [MS_W-1:0]   idle_timeout_ms;
        logic [MS_W-1:0]   notice_ms;
        logic [MODE_W-1:0] mode_limit;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STEPS-1:0] step_bits;
        logic                 button_before;
        logic                 screen_running;
        logic [MS_W-1:0]      screen_left;
        logic                 notice_running;
        logic [MS_W-1:0]      notice_left;
        logic [MODE_W-1:0]    mode_count;
    } seq_state_t;

endpackage

// ===== hw/rtl/dss_next_state.sv =====
// Next-state logic for one tick: button edge, timer countdown, step
// transitions and step actions. Depends on dss_pkg.
module dss_next_state (
    input  dss_pkg::cfg_t          cfg,
    input  dss_pkg::seq_state_t    cur,
    input  logic                   button_pressed,
    input  logic [15:0]            elapsed_ms,
    output dss_pkg::seq_state_t    nxt
);
    import dss_pkg::*;

    logic                 rise;
    logic                 scr_run;
    logic [MS_W-1:0]      scr_left;
    logic                 ntc_run;
    logic [MS_W-1:0]      ntc_left;
    logic [NUM_STEPS-1:0] old;
    logic [NUM_STEPS-1:0] clr;
    logic [NUM_STEPS-1:0] set;
    logic [NUM_STEPS-1:0] steps;
    logic [MODE_W-1:0]    mode;

    // Detect rising edge of the button
    assign rise = button_pressed & ~cur.button_before;
    assign old  = cur.step_bits;

    // Count down both timers; stop one when elapsed exceeds what is left
    always_comb begin
        scr_run  = cur.screen_running;
        scr_left = cur.screen_left;
        if (cur.screen_running) begin
            if (elapsed_ms > cur.screen_left) begin
                scr_run  = 1'b0;
                scr_left = '0;
            end else begin
                scr_left = cur.screen_left - elapsed_ms;
            end
        end
        ntc_run  = cur.notice_running;
        ntc_left = cur.notice_left;
        if (cur.notice_running) begin
            if (elapsed_ms > cur.notice_left) begin
                ntc_run  = 1'b0;
                ntc_left = '0;
            end else begin
                ntc_left = cur.notice_left - elapsed_ms;
            end
        end
    end

    // Evaluate all transitions from the old flags, clear then set
    always_comb begin
        clr = '0;
        set = '0;
        if (old[STEP_INIT]) begin
            clr[STEP_INIT] = 1'b1;  set[STEP_START] = 1'b1;
        end
        if (old[STEP_START]) begin
            clr[STEP_START] = 1'b1; set[STEP_ON] = 1'b1;
        end
        if (old[STEP_ON] && rise) begin
            clr[STEP_ON] = 1'b1;    set[STEP_NEXT] = 1'b1;
        end
        if (old[STEP_NEXT]) begin
            clr[STEP_NEXT] = 1'b1;  set[STEP_ON] = 1'b1;
        end
        if (old[STEP_ON] && !scr_run) begin
            clr[STEP_ON] = 1'b1;    set[STEP_GTS] = 1'b1;
        end
        if (old[STEP_SLEEP] && rise) begin
            clr[STEP_SLEEP] = 1'b1; set[STEP_WAKE] = 1'b1;
        end
        if (old[STEP_WAKE]) begin
            clr[STEP_WAKE] = 1'b1;  set[STEP_ON] = 1'b1;
        end
        if (old[STEP_GTS] && !ntc_run) begin
            clr[STEP_GTS] = 1'b1;   set[STEP_SLEEP] = 1'b1;
        end
        steps = (old & ~clr) | set;
    end

    // Run step actions in order: start, next_screen, going_to_sleep, waking
    always_comb begin
        nxt                = cur;
        nxt.step_bits      = steps;
        nxt.button_before  = button_pressed;
        nxt.screen_running = scr_run;
        nxt.screen_left    = scr_left;
        nxt.notice_running = ntc_run;
        nxt.notice_left    = ntc_left;
        mode               = cur.mode_count;

        if (steps[STEP_START] && !nxt.screen_running) begin
            nxt.screen_running = 1'b1;
            nxt.screen_left    = cfg.power_on_timeout_ms;
        end
        if (steps[STEP_NEXT]) begin
            if (cur.mode_count > cfg.mode_limit) begin
                mode = '0;
            end else begin
                mode = cur.mode_count + 1'b1;
            end
            nxt.screen_running = 1'b1;
            nxt.screen_left    = cfg.idle_timeout_ms;
        end
        if (steps[STEP_GTS] && !nxt.notice_running) begin
            nxt.notice_running = 1'b1;
            nxt.notice_left    = cfg.notice_ms;
        end
        if (steps[STEP_WAKE] && !nxt.screen_running) begin
            nxt.screen_running = 1'b1;
            nxt.screen_left    = cfg.idle_timeout_ms;
        end
        nxt.mode_count = mode;
    end

endmodule

// ===== hw/rtl/display_sleep_step_sequencer.sv =====
// Top level of the display sleep step sequencer: config registers, state
// registers and the result register. Depends on dss_pkg, dss_next_state.
//
// Usage:
//   Slave stream (s_*) carries one tick per item: the button level and the
//   milliseconds elapsed since the previous tick. Master stream (m_*) carries
//   exactly one result per tick: the step flags after the tick, the current
//   screen page and the four display action strobes.
//   The configuration port writes one register per cycle when cfg_wr_en is
//   high; write it only while no tick is in flight.
//   The result is registered: a tick accepted at a clock edge shows its
//   result on m_* after that edge. Throughput is one tick per cycle while
//   the receiver keeps up; state and result registers update in the accept cycle.
//   When the receiver stalls, the result register holds and s_tready drops
//   until the result is taken; s_tready is high whenever the result register
//   is empty or being drained in the same cycle.
//   Synchronous reset (aresetn low) restores the register defaults, sets
//   only the init step, clears timers, mode count and the result valid.
module display_sleep_step_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] button_pressed, [16:1] elapsed_ms, [23:17] zero
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [6:0] step_flags, [10:7] screen_mode,
                                   // [11] refresh_screen, [12] show_notice,
                                   // [13] sleep_display, [14] wake_display,
                                   // [15] zero
);
    import dss_pkg::*;

    cfg_t        cfg_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;
    logic        accept;

    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_on_timeout_ms <= POWER_ON_TIMEOUT_RST;
            cfg_reg.idle_timeout_ms     <= IDLE_TIMEOUT_RST;
            cfg_reg.notice_ms           <= NOTICE_RST;
            cfg_reg.mode_limit          <= MODE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_POWER_ON_TIMEOUT: cfg_reg.power_on_timeout_ms <= cfg_wdata;
                REG_IDLE_TIMEOUT:     cfg_reg.idle_timeout_ms     <= cfg_wdata;
                REG_NOTICE:           cfg_reg.notice_ms           <= cfg_wdata;
                REG_MODE_LIMIT:       cfg_reg.mode_limit          <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    dss_next_state u_next (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .button_pressed (s_tdata[0]),
        .elapsed_ms     (s_tdata[16:1]),
        .nxt            (state_next)
    );

    // Pack the result item from the new state
    assign out_data_next = {1'b0,
                            state_next.step_bits[STEP_WAKE],
                            state_next.step_bits[STEP_SLEEP],
                            state_next.step_bits[STEP_GTS],
                            state_next.step_bits[STEP_ON],
                            state_next.mode_count,
                            state_next.step_bits};

    // Advance sequencer state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.step_bits      <= STEPS_RST;
            state_reg.button_before  <= 1'b0;
            state_reg.screen_running <= 1'b0;
            state_reg.screen_left    <= '0;
            state_reg.notice_running <= 1'b0;
            state_reg.notice_left    <= '0;
            state_reg.mode_count     <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/dss_checker.sv =====
// Port-level assertions for the display sleep step sequencer, bound to the
// top level. Depends on display_sleep_step_sequencer ports only.
module dss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Result register is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every accepted item yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

    // Do not take an item while a stalled result would be overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input ready while result stalled");

    // Action strobes mirror their step flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] == m_tdata[2]) && (m_tdata[12] == m_tdata[3]) &&
                     (m_tdata[13] == m_tdata[4]) && (m_tdata[14] == m_tdata[5]))
        else $error("action strobe differs from step flag");

    // Stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind display_sleep_step_sequencer dss_checker u_dss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
